/* hw/rtl/qn_pkg.sv */
// Shared types and constants for the quaternion normalize pipeline.
// No dependencies; every module of the block imports this package.
package qn_pkg;

    // Component and intermediate widths, fixed by the 16-bit input format
    localparam int COMP_W   = 16;
    localparam int NUM_COMP = 4;
    localparam int SQ_W     = 31;   // square of a 16-bit signed value, at most 2^30
    localparam int PAIR_W   = 32;   // sum of two squares
    localparam int SUM_W    = 33;   // sum of four squares, at most 2^32
    localparam int RAD_W    = 34;   // radicand padded to whole bit pairs
    localparam int ROOT_W   = 17;   // one root bit per sqrt stage
    localparam int REM_W    = 20;   // sqrt partial remainder after shift-in
    localparam int MAG_W    = 17;   // rounded length, 0 .. 65536

    // Output saturation limits
    localparam int UNIT_POS_MAX = 32767;
    localparam int UNIT_NEG_MAX = 32768;

    // Stream beat layout
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 88;
    localparam int MAG_LSB    = 64;
    localparam int DATA_PAD_W = OUT_DATA_W - MAG_LSB - MAG_W;

    // Four components, w in the lowest slot
    typedef logic [NUM_COMP-1:0][COMP_W-1:0] t_quat;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

/* hw/rtl/qn_sumsq.sv */
// Sum-of-squares front end: squares, pair sums, total, zero detect.
// Depends on qn_pkg. Three register stages, all advanced by i_en.
module qn_sumsq import qn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_quat            i_quat,
    output t_ctl             o_ctl,
    output logic [SUM_W-1:0] o_sum,
    output t_quat            o_quat
);

    logic signed [2*COMP_W-1:0] w_prod [NUM_COMP];
    t_ctl                       n_ctl1;

    t_ctl              r_ctl1, r_ctl2, r_ctl3;
    logic [SQ_W-1:0]   r_sq   [NUM_COMP];
    logic [PAIR_W-1:0] r_pair [2];
    logic [SUM_W-1:0]  r_sum;
    t_quat             r_quat1, r_quat2, r_quat3;

    // Square each component; the zero flag comes straight from the inputs
    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_prod[k] = $signed(i_quat[k]) * $signed(i_quat[k]);
        end
        n_ctl1.valid = i_valid;
        n_ctl1.zero  = (i_quat == '0);
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    // Advance payload: squares, pair sums, total
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                r_sq[k] <= w_prod[k][SQ_W-1:0];
            end
            r_pair[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_pair[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_sum     <= {1'b0, r_pair[0]} + {1'b0, r_pair[1]};
            r_quat1   <= i_quat;
            r_quat2   <= r_quat1;
            r_quat3   <= r_quat2;
        end
    end

    assign o_ctl  = r_ctl3;
    assign o_sum  = r_sum;
    assign o_quat = r_quat3;

endmodule

/* hw/rtl/qn_sqrt.sv */
// Pipelined integer square root, one root bit per stage, plus a rounding stage.
// Depends on qn_pkg. Carries control and the components alongside.
module qn_sqrt import qn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [SUM_W-1:0] i_sum,
    input  t_quat            i_quat,
    output t_ctl             o_ctl,
    output logic [MAG_W-1:0] o_mag,
    output t_quat            o_quat
);

    localparam int STEPS = ROOT_W;

    logic [REM_W-1:0]  w_rem_src  [STEPS];
    logic [ROOT_W-1:0] w_root_src [STEPS];
    logic [RAD_W-1:0]  w_rad_src  [STEPS];
    t_ctl              w_ctl_src  [STEPS];
    t_quat             w_quat_src [STEPS];
    logic [REM_W-1:0]  w_test     [STEPS];
    logic [REM_W-1:0]  w_trial    [STEPS];
    logic [REM_W-1:0]  n_rem      [STEPS];
    logic [ROOT_W-1:0] n_root     [STEPS];

    t_ctl              r_ctl  [STEPS];
    logic [REM_W-1:0]  r_rem  [STEPS];
    logic [ROOT_W-1:0] r_root [STEPS];
    logic [RAD_W-1:0]  r_rad  [STEPS];
    t_quat             r_quat [STEPS];
    t_ctl              r_ctl_out;
    logic [MAG_W-1:0]  r_mag;
    t_quat             r_quat_out;

    // One digit step per stage: bring in two radicand bits, try root*4+1
    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            if (s == 0) begin
                w_rem_src[s]  = '0;
                w_root_src[s] = '0;
                w_rad_src[s]  = {1'b0, i_sum};
                w_ctl_src[s]  = i_ctl;
                w_quat_src[s] = i_quat;
            end else begin
                w_rem_src[s]  = r_rem[s-1];
                w_root_src[s] = r_root[s-1];
                w_rad_src[s]  = r_rad[s-1];
                w_ctl_src[s]  = r_ctl[s-1];
                w_quat_src[s] = r_quat[s-1];
            end
            w_test[s]  = {w_rem_src[s][REM_W-3:0], w_rad_src[s][RAD_W-1 -: 2]};
            w_trial[s] = REM_W'({w_root_src[s], 2'b01});
            if (w_test[s] >= w_trial[s]) begin
                n_rem[s]  = w_test[s] - w_trial[s];
                n_root[s] = {w_root_src[s][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[s]  = w_test[s];
                n_root[s] = {w_root_src[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STEPS; s++) begin
                r_ctl[s] <= '0;
            end
            r_ctl_out <= '0;
        end else if (i_en) begin
            for (int s = 0; s < STEPS; s++) begin
                r_ctl[s] <= w_ctl_src[s];
            end
            r_ctl_out <= r_ctl[STEPS-1];
        end
    end

    // Advance payload; round up when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STEPS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= w_rad_src[s] << 2;
                r_quat[s] <= w_quat_src[s];
            end
            r_mag      <= r_root[STEPS-1]
                        + MAG_W'(r_rem[STEPS-1] > REM_W'(r_root[STEPS-1]));
            r_quat_out <= r_quat[STEPS-1];
        end
    end

    assign o_ctl  = r_ctl_out;
    assign o_mag  = r_mag;
    assign o_quat = r_quat_out;

endmodule

/* hw/rtl/qn_div.sv */
// Four-lane pipelined restoring divider: |c| * 2^FRAC_BITS / magnitude,
// rounded to nearest, then sign, saturation and zero-length forcing. Uses qn_pkg.
module qn_div import qn_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [MAG_W-1:0] i_mag,
    input  t_quat            i_quat,
    output t_ctl             o_ctl,
    output logic [MAG_W-1:0] o_mag,
    output t_quat            o_unit
);

    localparam int QW = FRAC_BITS + 1;           // quotient bits, one per stage
    localparam int NW = QW + MAG_W;              // numerator width
    localparam int PW = MAG_W + 1;               // partial remainder, below 2*mag
    localparam int QX = (QW > MAG_W) ? QW : MAG_W;
    localparam int ST = QW + 1;                  // prep stage plus step stages

    typedef logic [NUM_COMP-1:0][PW-1:0] t_part;
    typedef logic [NUM_COMP-1:0][QW-1:0] t_low;

    logic [COMP_W-1:0] w_abs [NUM_COMP];
    logic [NW-1:0]     w_num [NUM_COMP];
    t_part             n_part [ST];
    t_low              n_low  [ST];
    logic [PW:0]       w_shift;
    logic              w_ge;
    logic [QX-1:0]     w_q;
    t_quat             n_unit;

    t_ctl             r_ctl  [ST];
    t_part            r_part [ST];
    t_low             r_low  [ST];
    logic [PW-1:0]    r_den  [ST];
    logic [MAG_W-1:0] r_mag  [ST];
    logic [NUM_COMP-1:0] r_neg [ST];
    t_ctl             r_ctl_out;
    logic [MAG_W-1:0] r_mag_out;
    t_quat            r_unit;

    // Prep: numerator = |c| * 2^(FRAC_BITS+1) + mag, split into head and tail.
    // Steps: shift one numerator bit into the remainder, subtract 2*mag if it fits
    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_abs[k] = i_quat[k][COMP_W-1] ? (COMP_W'(0) - i_quat[k]) : i_quat[k];
            w_num[k] = NW'({w_abs[k], {QW{1'b0}}}) + NW'(i_mag);
            n_part[0][k] = {1'b0, w_num[k][NW-1:QW]};
            n_low[0][k]  = w_num[k][QW-1:0];
        end
        w_shift = '0;
        w_ge    = 1'b0;
        for (int t = 1; t < ST; t++) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                w_shift = {r_part[t-1][k], r_low[t-1][k][QW-1]};
                w_ge    = (w_shift >= {1'b0, r_den[t-1]});
                n_part[t][k] = w_ge ? PW'(w_shift - {1'b0, r_den[t-1]}) : PW'(w_shift);
                n_low[t][k]  = {r_low[t-1][k][QW-2:0], w_ge};
            end
        end
    end

    // Sign, saturate, and force zeros for a zero-length input
    always_comb begin
        w_q = '0;
        for (int k = 0; k < NUM_COMP; k++) begin
            w_q = QX'(r_low[ST-1][k]);
            if (r_ctl[ST-1].zero) begin
                n_unit[k] = '0;
            end else if (r_neg[ST-1][k]) begin
                n_unit[k] = (w_q > QX'(UNIT_NEG_MAX))
                          ? (COMP_W'(0) - COMP_W'(UNIT_NEG_MAX))
                          : (COMP_W'(0) - w_q[COMP_W-1:0]);
            end else begin
                n_unit[k] = (w_q > QX'(UNIT_POS_MAX)) ? COMP_W'(UNIT_POS_MAX)
                                                      : w_q[COMP_W-1:0];
            end
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < ST; t++) begin
                r_ctl[t] <= '0;
            end
            r_ctl_out <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int t = 1; t < ST; t++) begin
                r_ctl[t] <= r_ctl[t-1];
            end
            r_ctl_out <= r_ctl[ST-1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= {i_mag, 1'b0};
            r_mag[0] <= i_mag;
            for (int k = 0; k < NUM_COMP; k++) begin
                r_neg[0][k] <= i_quat[k][COMP_W-1];
            end
            for (int t = 1; t < ST; t++) begin
                r_den[t] <= r_den[t-1];
                r_mag[t] <= r_mag[t-1];
                r_neg[t] <= r_neg[t-1];
            end
            for (int t = 0; t < ST; t++) begin
                r_part[t] <= n_part[t];
                r_low[t]  <= n_low[t];
            end
            r_mag_out <= r_mag[ST-1];
            r_unit    <= n_unit;
        end
    end

    assign o_ctl  = r_ctl_out;
    assign o_mag  = r_mag_out;
    assign o_unit = r_unit;

endmodule

/* hw/rtl/quaternion_normalize_top.sv */
// Top level of the quaternion normalize block: stream ports, pipeline, output skid.
// Depends on qn_pkg, qn_sumsq, qn_sqrt and qn_div.
//
// Usage:
//   Slave channel takes one quaternion per beat: w, x, y, z as signed 16-bit
//   values with FRAC_BITS fraction bits. Master channel returns one beat per
//   input: the four unit components, the rounded length and a zero-length flag
//   in tuser (components and length are zero when it is set).
//   The accepting edge loads the first of FRAC_BITS + 25 register stages:
//   3 sum-of-squares stages, 17 root-bit stages and a rounding stage, a prep
//   stage, FRAC_BITS + 1 quotient-bit stages and a saturation stage, then the
//   output register, which drives o_m_tvalid. Throughput is one beat per cycle
//   while the skid register is empty; each root-bit and quotient-bit stage is
//   a single digit step.
//   Reset clears all valid bits, the output and skid valid flags among them;
//   payload registers, output and skid data included, are left as they are.
//   When the receiver stalls, the pipeline keeps moving until the next valid
//   beat leaves it, and the skid register catches that beat; o_s_tready then
//   drops and the whole pipeline holds until the skid drains.
module quaternion_normalize_top import qn_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // in_w, in_x, in_y, in_z
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // unit_w, unit_x, unit_y, unit_z, magnitude
    output logic                  o_m_tuser    // zero_error
);

    logic             w_en;
    t_ctl             w_sq_ctl;
    logic [SUM_W-1:0] w_sq_sum;
    t_quat            w_sq_quat;
    t_ctl             w_rt_ctl;
    logic [MAG_W-1:0] w_rt_mag;
    t_quat            w_rt_quat;
    t_ctl             w_dv_ctl;
    logic [MAG_W-1:0] w_dv_mag;
    t_quat            w_dv_unit;
    logic [OUT_DATA_W-1:0] w_pipe_data;
    logic             w_out_free;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  r_skid_user;

    // Whole pipeline advances while the skid register is empty
    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    qn_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_quat  (t_quat'(i_s_tdata)),
        .o_ctl   (w_sq_ctl),
        .o_sum   (w_sq_sum),
        .o_quat  (w_sq_quat)
    );

    qn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_sq_ctl),
        .i_sum   (w_sq_sum),
        .i_quat  (w_sq_quat),
        .o_ctl   (w_rt_ctl),
        .o_mag   (w_rt_mag),
        .o_quat  (w_rt_quat)
    );

    qn_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_rt_ctl),
        .i_mag   (w_rt_mag),
        .i_quat  (w_rt_quat),
        .o_ctl   (w_dv_ctl),
        .o_mag   (w_dv_mag),
        .o_unit  (w_dv_unit)
    );

    // Pack the beat: components low, magnitude above, zero padding on top
    assign w_pipe_data = {{DATA_PAD_W{1'b0}}, w_dv_mag, w_dv_unit};
    assign w_out_free  = !r_out_valid || i_m_tready;

    // Output register with skid: drain skid first, else take the pipeline beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_dv_ctl.valid) begin
            if (w_out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold or load payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_dv_ctl.valid) begin
            if (w_out_free) begin
                r_out_data <= w_pipe_data;
                r_out_user <= w_dv_ctl.zero;
            end else begin
                r_skid_data <= w_pipe_data;
                r_skid_user <= w_dv_ctl.zero;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

/* hw/rtl/qn_checker.sv */
// Port-level checks for quaternion_normalize_top, attached by bind.
// Depends on qn_pkg for the beat layout.
module qn_checker import qn_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    // A stalled beat stays put
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // Zero-length flag comes with all-zero components and length
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("zero_error beat carries nonzero data");

    // A nonzero input always has a nonzero rounded length
    a_mag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[MAG_LSB +: MAG_W] != '0)
        else $error("zero magnitude without zero_error");

    // With the output register empty the skid is empty, so input is open
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output register is empty");

endmodule

bind quaternion_normalize_top qn_checker u_qn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
